/* hw/rtl/rrs_pkg.sv */
// Shared constants for the response-ratio scheduler: slot count, field widths
// and the widths of the ratio cross-multiplication. No dependencies.
package rrs_pkg;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned SERVICE_BITS = 10;
  localparam int unsigned TICK_BITS    = 16;

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W  =
      ((TICK_BITS > SERVICE_BITS) ? TICK_BITS : SERVICE_BITS) + 1;
  localparam int unsigned PROD_W = SUM_W + SERVICE_BITS;

  localparam int unsigned IN_SERVICE_W = 10;
  localparam int unsigned OUT_TICK_W   = 16;
  localparam int unsigned OUT_SLOT_W   = 4;

  typedef logic [SLOT_W-1:0]       slot_idx_t;
  typedef logic [SERVICE_BITS-1:0] service_t;
  typedef logic [TICK_BITS-1:0]    tick_t;
  typedef logic [SUM_W-1:0]        ratio_sum_t;
  typedef logic [PROD_W-1:0]       ratio_prod_t;

endpackage

/* hw/rtl/response_ratio_scheduler.sv */
// Non-preemptive highest-response-ratio-next scheduler, one tick per input beat.
// Depends on rrs_pkg for slot count, field widths and the multiplier widths.
//
// Each input beat is one scheduling tick: an arriving job is admitted into the
// lowest free slot, a running job with no time left is retired, and when the
// processor is free every slot is scanned with one shared multiplier to start
// the waiting job with the greatest (wait + service) / service, compared exactly
// by cross-multiplication, ties going to the earlier arrival. One result beat
// follows each input beat. A tick skips the slot scan when a job keeps running;
// when a selection is made, the scan reads the slot memory once per slot, takes
// the first waiting job as the best, and compares each later one against it by
// forming the candidate product and then the best product. A tick also waits
// while the previous result beat has not been taken. A new beat is taken while
// the previous result still waits.
module response_ratio_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            arrive_i,
  input  logic [rrs_pkg::IN_SERVICE_W-1:0] service_time_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rrs_pkg::OUT_TICK_W-1:0]  tick_now_o,
  output logic [rrs_pkg::OUT_SLOT_W-1:0]  arrival_slot_o,
  output logic                            arrival_dropped_o,
  output logic                            running_valid_o,
  output logic [rrs_pkg::OUT_SLOT_W-1:0]  running_slot_o,
  output logic                            finished_valid_o,
  output logic [rrs_pkg::OUT_SLOT_W-1:0]  finished_slot_o
);
  import rrs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_MUL2   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [2:0] state_q, state_d;

  tick_t             tick_q, tick_d;
  logic [SLOTS-1:0]  busy_q, busy_d;
  logic              act_valid_q, act_valid_d;
  slot_idx_t         act_slot_q, act_slot_d;
  service_t          act_rem_q, act_rem_d;

  slot_idx_t         idx_q, idx_d;
  logic              have_best_q, have_best_d;
  slot_idx_t         best_q, best_d;
  tick_t             best_arr_q, best_arr_d;
  service_t          best_svc_q, best_svc_d;
  ratio_prod_t       lhs_q, lhs_d;

  slot_idx_t         arr_slot_q, arr_slot_d;
  logic              dropped_q, dropped_d;
  logic              fin_valid_q, fin_valid_d;
  slot_idx_t         fin_slot_q, fin_slot_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_TICK_W-1:0] out_tick_q, out_tick_d;
  logic [OUT_SLOT_W-1:0] out_arr_slot_q, out_arr_slot_d;
  logic                  out_dropped_q, out_dropped_d;
  logic                  out_run_valid_q, out_run_valid_d;
  logic [OUT_SLOT_W-1:0] out_run_slot_q, out_run_slot_d;
  logic                  out_fin_valid_q, out_fin_valid_d;
  logic [OUT_SLOT_W-1:0] out_fin_slot_q, out_fin_slot_d;

  tick_t     slot_arr_mem [SLOTS];
  service_t  slot_svc_mem [SLOTS];
  tick_t     rd_arr_q;
  service_t  rd_svc_q;

  logic        accept;
  logic        have_free;
  slot_idx_t   free_idx;
  service_t    svc_in;
  logic        mem_we;
  logic        retire;
  logic        last_slot;
  logic        out_free;

  ratio_sum_t  mul_a;
  service_t    mul_b;
  ratio_prod_t prod;
  logic        cand_wins;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_slot  = (idx_q == LAST_SLOT);
  assign retire     = act_valid_q && (act_rem_q == '0);

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        have_free = 1'b1;
        free_idx  = SLOT_W'(i);
      end
    end
  end

  assign svc_in = (service_time_i == '0) ? SERVICE_BITS'(1) : SERVICE_BITS'(service_time_i);
  assign mem_we = accept && arrive_i && have_free;

  // The single multiplier forms the candidate product first, then the best product.
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = SUM_W'(tick_q - rd_arr_q) + SUM_W'(rd_svc_q);
      mul_b = best_svc_q;
    end else begin
      mul_a = SUM_W'(tick_q - best_arr_q) + SUM_W'(best_svc_q);
      mul_b = rd_svc_q;
    end
  end

  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign cand_wins = (lhs_q > prod) || ((lhs_q == prod) && (rd_arr_q < best_arr_q));

  always_comb begin
    state_d         = state_q;
    tick_d          = tick_q;
    busy_d          = busy_q;
    act_valid_d     = act_valid_q;
    act_slot_d      = act_slot_q;
    act_rem_d       = act_rem_q;
    idx_d           = idx_q;
    have_best_d     = have_best_q;
    best_d          = best_q;
    best_arr_d      = best_arr_q;
    best_svc_d      = best_svc_q;
    lhs_d           = lhs_q;
    arr_slot_d      = arr_slot_q;
    dropped_d       = dropped_q;
    fin_valid_d     = fin_valid_q;
    fin_slot_d      = fin_slot_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_tick_d      = out_tick_q;
    out_arr_slot_d  = out_arr_slot_q;
    out_dropped_d   = out_dropped_q;
    out_run_valid_d = out_run_valid_q;
    out_run_slot_d  = out_run_slot_q;
    out_fin_valid_d = out_fin_valid_q;
    out_fin_slot_d  = out_fin_slot_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          arr_slot_d  = mem_we ? free_idx : '0;
          dropped_d   = arrive_i && !have_free;
          fin_valid_d = retire;
          fin_slot_d  = retire ? act_slot_q : '0;
          if (mem_we) begin
            busy_d[free_idx] = 1'b1;
          end
          if (retire) begin
            busy_d[act_slot_q] = 1'b0;
            act_valid_d        = 1'b0;
          end
          have_best_d = 1'b0;
          idx_d       = '0;
          if (retire || !act_valid_q) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_READ: begin
        if (busy_q[idx_q]) begin
          state_d = ST_MUL1;
        end else if (last_slot) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_MUL1: begin
        if (!have_best_q) begin
          have_best_d = 1'b1;
          best_d      = idx_q;
          best_arr_d  = rd_arr_q;
          best_svc_d  = rd_svc_q;
          if (last_slot) begin
            state_d = ST_COMMIT;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = ST_READ;
          end
        end else begin
          lhs_d   = prod;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (cand_wins) begin
          best_d     = idx_q;
          best_arr_d = rd_arr_q;
          best_svc_d = rd_svc_q;
        end
        if (last_slot) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = ST_READ;
        end
      end
      ST_COMMIT: begin
        if (have_best_q) begin
          act_valid_d = 1'b1;
          act_slot_d  = best_q;
          act_rem_d   = best_svc_q;
        end
        have_best_d = 1'b0;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_tick_d      = OUT_TICK_W'(tick_q);
          out_arr_slot_d  = OUT_SLOT_W'(arr_slot_q);
          out_dropped_d   = dropped_q;
          out_run_valid_d = act_valid_q;
          out_run_slot_d  = act_valid_q ? OUT_SLOT_W'(act_slot_q) : '0;
          out_fin_valid_d = fin_valid_q;
          out_fin_slot_d  = OUT_SLOT_W'(fin_slot_q);
          if (act_valid_q && (act_rem_q != '0)) begin
            act_rem_d = act_rem_q - SERVICE_BITS'(1);
          end
          if (tick_q != '1) begin
            tick_d = tick_q + TICK_BITS'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      busy_q      <= '0;
      act_valid_q <= 1'b0;
      act_slot_q  <= '0;
      act_rem_q   <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      busy_q      <= busy_d;
      act_valid_q <= act_valid_d;
      act_slot_q  <= act_slot_d;
      act_rem_q   <= act_rem_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q           <= idx_d;
    best_q          <= best_d;
    best_arr_q      <= best_arr_d;
    best_svc_q      <= best_svc_d;
    lhs_q           <= lhs_d;
    arr_slot_q      <= arr_slot_d;
    dropped_q       <= dropped_d;
    fin_valid_q     <= fin_valid_d;
    fin_slot_q      <= fin_slot_d;
    out_tick_q      <= out_tick_d;
    out_arr_slot_q  <= out_arr_slot_d;
    out_dropped_q   <= out_dropped_d;
    out_run_valid_q <= out_run_valid_d;
    out_run_slot_q  <= out_run_slot_d;
    out_fin_valid_q <= out_fin_valid_d;
    out_fin_slot_q  <= out_fin_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_arr_mem[free_idx] <= tick_q;
      slot_svc_mem[free_idx] <= svc_in;
    end
    rd_arr_q <= slot_arr_mem[idx_q];
    rd_svc_q <= slot_svc_mem[idx_q];
  end

  assign out_valid_o       = out_valid_q;
  assign tick_now_o        = out_tick_q;
  assign arrival_slot_o    = out_arr_slot_q;
  assign arrival_dropped_o = out_dropped_q;
  assign running_valid_o   = out_run_valid_q;
  assign running_slot_o    = out_run_slot_q;
  assign finished_valid_o  = out_fin_valid_q;
  assign finished_slot_o   = out_fin_slot_q;

  // The running job always holds its slot.
  a_active_slot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_valid_q |-> busy_q[act_slot_q])
    else $error("running job does not hold a busy slot");

  // The best candidate of a scan is always a waiting job.
  a_best_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> busy_q[best_q])
    else $error("selected candidate slot is not busy");

  // An accepted beat always starts the tick sequence.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ || state_q == ST_COMMIT))
    else $error("accepted beat did not start a tick");

  // The tick counter never moves backward.
  a_tick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q >= $past(tick_q))
    else $error("tick counter decreased");

endmodule
